/* hdl/prfp_pkg.sv */
// ----------------------------------------------------------------------------
// Panel reply frame parser package
// Byte codes, frame lengths, event kinds and the result word shared by the
// parser and the top level.
// ----------------------------------------------------------------------------
package prfp_pkg;

    localparam logic [7:0] HEAD_BYTE   = 8'hA5;
    localparam logic [7:0] END_BYTE    = 8'h5A;
    localparam logic [7:0] KIND_SETUP  = 8'h20;
    localparam logic [7:0] KIND_BUTTON = 8'h01;
    localparam logic [7:0] SETUP_CODE  = 8'h01;
    localparam logic [7:0] FILL_BYTE   = 8'hFF;

    localparam logic [2:0] SETUP_LEN   = 3'd6;
    localparam logic [2:0] BUTTON_LEN  = 3'd4;
    localparam logic [2:0] NO_LEN      = 3'd0;

    localparam logic [1:0] STATUS_LAST = 2'd3;

    typedef enum logic [1:0] {
        EV_SETUP  = 2'd0,
        EV_BUTTON = 2'd1,
        EV_STATUS = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic        valid;
        event_kind_t kind;
        logic [7:0]  first_curve_id;
        logic [7:0]  second_curve_id;
        logic [7:0]  button_code;
        logic [7:0]  status_code;
    } result_t;

endpackage

/* hdl/prfp_parser.sv */
// ----------------------------------------------------------------------------
// Panel reply frame parser core
// Holds the frame state and works out, for each accepted word, the next
// state and the event that the word completes, if any.
// ----------------------------------------------------------------------------
module prfp_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic              line_error,
    output prfp_pkg::result_t result
);
    import prfp_pkg::*;

    logic [1:0] status_count_reg;
    logic [1:0] status_count_next;
    logic [7:0] status_first_reg;
    logic [7:0] status_first_next;
    logic [2:0] frame_count_reg;
    logic [2:0] frame_count_next;
    logic [2:0] expected_length_reg;
    logic [2:0] expected_length_next;
    logic [7:0] frame_reg [1:4];
    logic [7:0] frame_next [1:4];
    logic [2:0] count_inc;
    logic [2:0] length_now;

    always_comb
    begin
        status_count_next    = status_count_reg;
        status_first_next    = status_first_reg;
        frame_count_next     = frame_count_reg;
        expected_length_next = expected_length_reg;
        frame_next           = frame_reg;
        count_inc            = frame_count_reg + 3'd1;
        length_now           = expected_length_reg;
        result               = '0;
        result.kind          = EV_SETUP;

        if (accept)
        begin
            if (line_error)
            begin
                status_count_next    = 2'd0;
                frame_count_next     = 3'd0;
                expected_length_next = NO_LEN;
            end
            else if ((status_count_reg != 2'd0) || (frame_count_reg == 3'd0))
            begin
                if ((status_count_reg != 2'd0) && (rx_byte == FILL_BYTE))
                begin
                    if (status_count_reg == STATUS_LAST)
                    begin
                        status_count_next  = 2'd0;
                        result.valid       = 1'b1;
                        result.kind        = EV_STATUS;
                        result.status_code = status_first_reg;
                    end
                    else
                    begin
                        status_count_next = status_count_reg + 2'd1;
                    end
                end
                else if (rx_byte == HEAD_BYTE)
                begin
                    frame_count_next     = 3'd1;
                    expected_length_next = NO_LEN;
                    status_count_next    = 2'd0;
                end
                else
                begin
                    status_first_next = rx_byte;
                    status_count_next = 2'd1;
                end
            end
            else if (frame_count_reg >= SETUP_LEN)
            begin
                frame_count_next     = 3'd0;
                expected_length_next = NO_LEN;
            end
            else
            begin
                case (frame_count_reg)
                    3'd1:    frame_next[1] = rx_byte;
                    3'd2:    frame_next[2] = rx_byte;
                    3'd3:    frame_next[3] = rx_byte;
                    3'd4:    frame_next[4] = rx_byte;
                    default: ;
                endcase
                frame_count_next = count_inc;

                if (count_inc == 3'd2)
                begin
                    if (rx_byte == KIND_SETUP)
                    begin
                        length_now = SETUP_LEN;
                    end
                    else if (rx_byte == KIND_BUTTON)
                    begin
                        length_now = BUTTON_LEN;
                    end
                    else
                    begin
                        length_now       = NO_LEN;
                        frame_count_next = 3'd0;
                    end
                end
                expected_length_next = length_now;

                if ((length_now != NO_LEN) && (count_inc == length_now))
                begin
                    frame_count_next     = 3'd0;
                    expected_length_next = NO_LEN;
                    if (rx_byte == END_BYTE)
                    begin
                        if ((length_now == SETUP_LEN) && (frame_reg[1] == KIND_SETUP)
                            && (frame_reg[2] == SETUP_CODE))
                        begin
                            result.valid           = 1'b1;
                            result.kind            = EV_SETUP;
                            result.first_curve_id  = frame_reg[3];
                            result.second_curve_id = frame_reg[4];
                        end
                        else if ((length_now == BUTTON_LEN)
                                 && (frame_reg[1] == KIND_BUTTON))
                        begin
                            result.valid       = 1'b1;
                            result.kind        = EV_BUTTON;
                            result.button_code = frame_reg[2];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_count_reg    <= 2'd0;
            frame_count_reg     <= 3'd0;
            expected_length_reg <= NO_LEN;
        end
        else
        begin
            status_count_reg    <= status_count_next;
            frame_count_reg     <= frame_count_next;
            expected_length_reg <= expected_length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_first_reg <= status_first_next;
        frame_reg        <= frame_next;
    end

`ifndef SYNTHESIS
    // A status frame and a custom frame are never open together.
    a_one_frame_open: assert property (@(posedge clk) disable iff (!rst_n)
        !((status_count_reg != 2'd0) && (frame_count_reg != 3'd0)))
        else $error("status and custom frames open together");

    // A custom frame always closes before its count reaches the setup length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg < SETUP_LEN)
        else $error("custom frame count out of range");

    // A length is known only once the kind byte has been taken.
    a_length_known: assert property (@(posedge clk) disable iff (!rst_n)
        (expected_length_reg != NO_LEN) |->
            ((frame_count_reg >= 3'd2)
             && ((expected_length_reg == SETUP_LEN)
                 || (expected_length_reg == BUTTON_LEN))))
        else $error("expected length inconsistent with frame count");

    // A line error never yields an event.
    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && line_error) |-> !result.valid)
        else $error("event given on a line error");
`endif

endmodule

/* hdl/panel_reply_frame_parser.sv */
// ----------------------------------------------------------------------------
// Panel reply frame parser
// Splits bytes received from a display panel into setup, button and status
// frames and gives one event word for each complete, well-formed frame.
//
//   Channel | Handshake            | Word
//   --------+----------------------+---------------------------------------
//   in      | in_valid, in_stall   | rx_byte, line_error
//   out     | out_valid, out_stall | event_kind, first_curve_id,
//           |                      | second_curve_id, button_code, status_code
//
// One word is taken in every unstalled cycle; an event appears on the output
// in the cycle after its completing word, set by the single result register.
// Reset clears the frame counters and the output valid; no clearing pass.
// Input is stalled only while a held event waits on a stalled output.
// ----------------------------------------------------------------------------
module panel_reply_frame_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       line_error,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] event_kind,
    output logic [7:0] first_curve_id,
    output logic [7:0] second_curve_id,
    output logic [7:0] button_code,
    output logic [7:0] status_code
);
    import prfp_pkg::*;

    logic    accept;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    prfp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .line_error (line_error),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && result.valid)
        begin
            out_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_kind      = out_reg.kind;
    assign first_curve_id  = out_reg.first_curve_id;
    assign second_curve_id = out_reg.second_curve_id;
    assign button_code     = out_reg.button_code;
    assign status_code     = out_reg.status_code;

endmodule

/* test/tb_panel_reply_frame_parser.sv */
// ----------------------------------------------------------------------------
// Panel reply frame parser testbench
// Drives received bytes through the valid/stall input channel and checks every
// event word against a local parser model.
//
// The model keeps its own copy of the status and custom frame counters. Each
// accepted word updates the model, and each complete frame that it finds
// queues one expected event. The checker compares every accepted output word,
// field by field, with the oldest queued event. The sender and the receiver
// both idle at random. One phase runs with no idling at all. One phase holds
// the output off for a long stretch, so that the parser fills up and stalls
// its input. Stimulus starts with a short directed part and then mostly
// well-formed frames with random content, mixed with noise, broken frames and
// line errors.
// ----------------------------------------------------------------------------
module tb_panel_reply_frame_parser;

    import prfp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 660;
    localparam int CALM_WORDS   = 150;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  time_id;
        logic [7:0]  spectrum_id;
        logic [7:0]  button;
        logic [7:0]  status;
    } panel_event_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       line_error;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] event_kind;
    logic [7:0] first_curve_id;
    logic [7:0] second_curve_id;
    logic [7:0] button_code;
    logic [7:0] status_code;

    panel_event_t pending_events[$];

    logic [1:0] status_held;
    logic [7:0] status_byte;
    logic [7:0] frame_store [0:5];
    logic [2:0] frame_held;
    logic [2:0] frame_length;

    int  words_sent;
    int  mismatch_count;
    int  hold_request;
    bit  calm;

    panel_reply_frame_parser u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .line_error      (line_error),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_kind      (event_kind),
        .first_curve_id  (first_curve_id),
        .second_curve_id (second_curve_id),
        .button_code     (button_code),
        .status_code     (status_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void parse_word(input logic [7:0] b, input logic err);
        panel_event_t ev;
        logic [2:0]   len;
        ev = '0;
        if (err)
        begin
            frame_held   = 3'd0;
            frame_length = NO_LEN;
            status_held  = 2'd0;
            return;
        end
        if (status_held != 2'd0 && b == FILL_BYTE)
        begin
            if (status_held >= STATUS_LAST)
            begin
                status_held = 2'd0;
                ev.kind     = EV_STATUS;
                ev.status   = status_byte;
                pending_events.push_back(ev);
            end
            else
                status_held = status_held + 2'd1;
            return;
        end
        if (status_held != 2'd0 || frame_held == 3'd0)
        begin
            if (b == HEAD_BYTE)
            begin
                frame_store[0] = HEAD_BYTE;
                frame_held     = 3'd1;
                frame_length   = NO_LEN;
                status_held    = 2'd0;
            end
            else
            begin
                status_byte = b;
                status_held = 2'd1;
            end
            return;
        end
        if (frame_held >= SETUP_LEN)
        begin
            frame_held   = 3'd0;
            frame_length = NO_LEN;
            return;
        end
        frame_store[frame_held] = b;
        frame_held = frame_held + 3'd1;
        if (frame_held == 3'd2)
        begin
            if (frame_store[1] == KIND_SETUP)
                frame_length = SETUP_LEN;
            else if (frame_store[1] == KIND_BUTTON)
                frame_length = BUTTON_LEN;
            else
            begin
                frame_held   = 3'd0;
                frame_length = NO_LEN;
                return;
            end
        end
        if (frame_length != NO_LEN && frame_held == frame_length)
        begin
            len          = frame_length;
            frame_held   = 3'd0;
            frame_length = NO_LEN;
            if (frame_store[len - 3'd1] != END_BYTE)
                return;
            if (len == SETUP_LEN && frame_store[2] == SETUP_CODE)
            begin
                ev.kind        = EV_SETUP;
                ev.time_id     = frame_store[3];
                ev.spectrum_id = frame_store[4];
                pending_events.push_back(ev);
            end
            else if (len == BUTTON_LEN)
            begin
                ev.kind   = EV_BUTTON;
                ev.button = frame_store[2];
                pending_events.push_back(ev);
            end
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input logic err);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        rx_byte    <= b;
        line_error <= err;
        do
            @(posedge clk);
        while (in_stall);
        parse_word(b, err);
        words_sent++;
    endtask

    task automatic send_frame_byte(input logic [7:0] b);
        if ($urandom_range(0, 59) == 0)
            send_word(rand_byte(), 1'b1);
        send_word(b, 1'b0);
    endtask

    task automatic send_random_frame();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 28)
        begin
            send_frame_byte(HEAD_BYTE);
            send_frame_byte(KIND_SETUP);
            send_frame_byte(($urandom_range(0, 9) == 0) ? rand_byte() : SETUP_CODE);
            send_frame_byte(rand_byte());
            send_frame_byte(rand_byte());
            send_frame_byte(($urandom_range(0, 9) == 0) ? rand_byte() : END_BYTE);
        end
        else if (pick < 52)
        begin
            send_frame_byte(HEAD_BYTE);
            send_frame_byte(KIND_BUTTON);
            send_frame_byte(rand_byte());
            send_frame_byte(($urandom_range(0, 9) == 0) ? rand_byte() : END_BYTE);
        end
        else if (pick < 80)
        begin
            send_frame_byte(($urandom_range(0, 15) == 0) ? FILL_BYTE : rand_byte());
            repeat (3)
                send_frame_byte(($urandom_range(0, 11) == 0) ? rand_byte() : FILL_BYTE);
        end
        else if (pick < 88)
        begin
            send_frame_byte(HEAD_BYTE);
            send_frame_byte(rand_byte());
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_frame_byte(rand_byte());
        end
    endtask

    task automatic test_custom_frames();
        send_word(HEAD_BYTE, 1'b0);
        send_word(KIND_SETUP, 1'b0);
        send_word(SETUP_CODE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(END_BYTE, 1'b0);
        send_word(HEAD_BYTE, 1'b0);
        send_word(KIND_BUTTON, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(END_BYTE, 1'b0);
    endtask

    task automatic test_status_frames();
        send_word(8'h00, 1'b0);
        repeat (3)
            send_word(FILL_BYTE, 1'b0);
        repeat (4)
            send_word(FILL_BYTE, 1'b0);
    endtask

    task automatic test_broken_frames();
        // A head byte abandons the open status frame; the bad kind byte is
        // then consumed without starting a new status frame.
        send_word(8'h3C, 1'b0);
        send_word(FILL_BYTE, 1'b0);
        send_word(HEAD_BYTE, 1'b0);
        send_word(8'h33, 1'b0);
        send_word(HEAD_BYTE, 1'b0);
        send_word(KIND_BUTTON, 1'b0);
        send_word(END_BYTE, 1'b1);
        send_word(HEAD_BYTE, 1'b0);
        send_word(KIND_BUTTON, 1'b0);
        send_word(8'h7E, 1'b0);
        send_word(8'h00, 1'b0);
    endtask

    task automatic test_random_stream();
        int target;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
            send_random_frame();
    endtask

    task automatic test_back_to_back();
        int target;
        calm   = 1'b1;
        target = words_sent + CALM_WORDS;
        while (words_sent < target)
            send_random_frame();
        calm = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_request = HOLD_CYCLES;
        repeat (10)
        begin
            send_word(rand_byte() & 8'h7F, 1'b0);
            repeat (3)
                send_word(FILL_BYTE, 1'b0);
        end
    endtask

    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left != 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        panel_event_t exp_ev;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("Unexpected event word: %0d %02h %02h %02h %02h",
                             event_kind, first_curve_id, second_curve_id,
                             button_code, status_code);
                mismatch_count++;
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                if (event_kind !== exp_ev.kind || first_curve_id !== exp_ev.time_id ||
                    second_curve_id !== exp_ev.spectrum_id ||
                    button_code !== exp_ev.button || status_code !== exp_ev.status)
                begin
                    if (mismatch_count < 10)
                        $display("Mismatch: exp %0d %02h %02h %02h %02h, got %0d %02h %02h %02h %02h",
                                 exp_ev.kind, exp_ev.time_id, exp_ev.spectrum_id,
                                 exp_ev.button, exp_ev.status, event_kind,
                                 first_curve_id, second_curve_id, button_code,
                                 status_code);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_panel_reply_frame_parser: FAIL");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        rx_byte        <= 8'h00;
        line_error     <= 1'b0;
        hold_request    = 0;
        calm            = 1'b0;
        words_sent      = 0;
        mismatch_count  = 0;
        status_held     = 2'd0;
        status_byte     = 8'h00;
        frame_held      = 3'd0;
        frame_length    = NO_LEN;
        for (int i = 0; i < 6; i++)
            frame_store[i] = 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_custom_frames();
        test_status_frames();
        test_broken_frames();
        test_random_stream();
        test_back_to_back();
        test_output_hold();
        test_random_stream();

        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("tb_panel_reply_frame_parser: PASS");
        else
            $display("tb_panel_reply_frame_parser: FAIL");
        $finish;
    end

endmodule
